// ===== rtl/lls_pkg.sv =====
// Package for the log line splitter and keyword flagger.
// Holds the input and result item types, record kinds and character constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lls_pkg;

  localparam int LINE_CHARS = 96;
  localparam logic [9:0] LINE_LIMIT_RESET = 10'd360;

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_LINE    = 2'd1,
    KIND_SUMMARY = 2'd2
  } record_kind_t;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  localparam logic [6:0] UC_A = 7'h41;
  localparam logic [6:0] UC_C = 7'h43;
  localparam logic [6:0] UC_E = 7'h45;
  localparam logic [6:0] UC_F = 7'h46;
  localparam logic [6:0] UC_I = 7'h49;
  localparam logic [6:0] UC_L = 7'h4C;
  localparam logic [6:0] UC_N = 7'h4E;
  localparam logic [6:0] UC_O = 7'h4F;
  localparam logic [6:0] UC_P = 7'h50;
  localparam logic [6:0] UC_R = 7'h52;
  localparam logic [6:0] LC_A = 7'h61;
  localparam logic [6:0] LC_Z = 7'h7A;
  localparam logic [6:0] CASE_OFFSET = 7'd32;

  typedef struct packed {
    logic       mode;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    record_kind_t record_kind;
    logic [6:0]   char_out;
    logic [6:0]   char_column;
    logic [9:0]   line_number;
    logic [6:0]   line_length;
    logic         error_flag;
    logic [9:0]   total_lines;
    logic         truncated;
    logic         last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/log_line_splitter_keyword_flagger.sv =====
// Top level of the log line splitter and keyword flagger.
// Depends on lls_pkg for the item types, record kinds and character constants.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one file byte per clock cycle and answers each in the same
// cycle's single pass of logic, writing its results into a four-entry result
// queue. Each result is registered and offered at the output once earlier
// results are taken. A data byte yields at most one result; an end-of-file
// item yields a line record and a summary, or a summary alone, so the output
// side may have to take two results for it. The input is ready whenever the
// queue has room for two results, which gives one item per cycle as long as
// the consumer takes one result per cycle. The line limit may be written at
// any time the block is idle and the configuration port is always ready.
module log_line_splitter_keyword_flagger
  import lls_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [9:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_item
);

  localparam int FIFO_DEPTH = 4;

  logic [9:0] line_limit;
  logic [6:0] column;
  logic [9:0] cur_line;
  logic       file_cut;
  logic       line_error;
  logic [6:0] recent_chars [4];

  logic [6:0] column_next;
  logic [9:0] cur_line_next;
  logic       file_cut_next;
  logic       line_error_next;
  logic [6:0] recent_chars_next [4];

  out_item_t  fifo_mem [FIFO_DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  logic       accept;
  logic       pop;
  logic [1:0] n_push;
  out_item_t  rec0;
  out_item_t  rec1;
  logic [9:0] limit;
  logic [7:0] clean_byte;
  logic [6:0] ch;
  logic [6:0] up;
  logic       hit;

  assign cfg_ready = 1'b1;
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && out_ready;
  assign in_ready  = (count <= 3'(FIFO_DEPTH - 2));
  assign accept    = in_valid && in_ready;
  assign out_item  = fifo_mem[rd_ptr];
  assign limit     = (line_limit == 10'd0) ? 10'd1 : line_limit;

  always_comb begin
    clean_byte = in_item.in_byte;
    if (clean_byte == CH_TAB) begin
      clean_byte = CH_SPACE;
    end
    if (!(clean_byte inside {[CH_SPACE:CH_TILDE]})) begin
      clean_byte = CH_DOT;
    end
    ch = clean_byte[6:0];
    up = (ch inside {[LC_A:LC_Z]}) ? (ch - CASE_OFFSET) : ch;
    hit = (up == UC_R && recent_chars[3] == UC_E && recent_chars[2] == UC_R &&
           recent_chars[1] == UC_R && recent_chars[0] == UC_O) ||
          (up == UC_L && recent_chars[2] == UC_F && recent_chars[1] == UC_A &&
           recent_chars[0] == UC_I) ||
          (up == UC_F && recent_chars[1] == UC_E && recent_chars[0] == UC_L) ||
          (up == UC_C && recent_chars[3] == UC_P && recent_chars[2] == UC_A &&
           recent_chars[1] == UC_N && recent_chars[0] == UC_I);
  end

  always_comb begin
    column_next       = column;
    cur_line_next     = cur_line;
    file_cut_next     = file_cut;
    line_error_next   = line_error;
    recent_chars_next = recent_chars;
    n_push            = 2'd0;
    rec0              = '0;
    rec1              = '0;
    if (accept) begin
      if (in_item.mode) begin
        if (column == 7'd0 && cur_line > 10'd1) begin
          rec0.record_kind = KIND_SUMMARY;
          rec0.total_lines = cur_line - 10'd1;
          rec0.truncated   = file_cut;
          rec0.last        = 1'b1;
          n_push           = 2'd1;
        end else begin
          rec0.record_kind = KIND_LINE;
          rec0.line_number = cur_line;
          rec0.line_length = column;
          rec0.error_flag  = line_error;
          rec1.record_kind = KIND_SUMMARY;
          rec1.total_lines = cur_line;
          rec1.truncated   = file_cut;
          rec1.last        = 1'b1;
          n_push           = 2'd2;
        end
        column_next       = 7'd0;
        cur_line_next     = 10'd1;
        file_cut_next     = 1'b0;
        line_error_next   = 1'b0;
        recent_chars_next = '{default: 7'd0};
      end else if (!file_cut && in_item.in_byte != CH_CR) begin
        if (in_item.in_byte == CH_LF) begin
          if (cur_line >= limit) begin
            file_cut_next = 1'b1;
          end else begin
            rec0.record_kind  = KIND_LINE;
            rec0.line_number  = cur_line;
            rec0.line_length  = column;
            rec0.error_flag   = line_error;
            rec0.last         = 1'b1;
            n_push            = 2'd1;
            cur_line_next     = cur_line + 10'd1;
            column_next       = 7'd0;
            line_error_next   = 1'b0;
            recent_chars_next = '{default: 7'd0};
          end
        end else if (column < 7'(LINE_CHARS)) begin
          rec0.record_kind     = KIND_CHAR;
          rec0.char_out        = ch;
          rec0.char_column     = column;
          rec0.line_number     = cur_line;
          rec0.last            = 1'b1;
          n_push               = 2'd1;
          line_error_next      = line_error | hit;
          recent_chars_next[3] = recent_chars[2];
          recent_chars_next[2] = recent_chars[1];
          recent_chars_next[1] = recent_chars[0];
          recent_chars_next[0] = up;
          column_next          = column + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit   <= LINE_LIMIT_RESET;
      column       <= 7'd0;
      cur_line     <= 10'd1;
      file_cut     <= 1'b0;
      line_error   <= 1'b0;
      recent_chars <= '{default: 7'd0};
      wr_ptr       <= 2'd0;
      rd_ptr       <= 2'd0;
      count        <= 3'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        line_limit <= cfg_data;
      end
      column       <= column_next;
      cur_line     <= cur_line_next;
      file_cut     <= file_cut_next;
      line_error   <= line_error_next;
      recent_chars <= recent_chars_next;
      wr_ptr       <= wr_ptr + n_push;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {1'b0, n_push} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fifo_mem[wr_ptr] <= rec0;
    end
    if (n_push == 2'd2) begin
      fifo_mem[wr_ptr + 2'd1] <= rec1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(FIFO_DEPTH))
    else $error("Result queue count exceeds its depth.");

  a_column_bound: assert property (@(posedge clk) disable iff (rst)
    column <= 7'(LINE_CHARS))
    else $error("Column runs past the kept line width.");

  a_cur_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    cur_line != 10'd0)
    else $error("Line number wrapped to zero.");

  a_cut_sticky: assert property (@(posedge clk) disable iff (rst)
    file_cut && !(accept && in_item.mode) |=> file_cut)
    else $error("Truncation mark cleared before end of file.");

  a_char_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.record_kind == KIND_CHAR |-> out_item.last)
    else $error("A character record is not the last result of its item.");

endmodule

`default_nettype wire
